/* src/swmd_pkg.sv */
// ----------------------------------------------------------------------------
// swmd_pkg
// Types, codes and saturating helpers shared by the swap market model drift
// block and its fixed point unit.
// ----------------------------------------------------------------------------
package swmd_pkg;

  localparam int FX_W       = 48;
  localparam int OUT_LIMIT  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  typedef logic signed [FX_W-1:0] fx_t;

  localparam fx_t FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_RATES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_FACTORS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALIVE_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NUMERAIRE   = 3'd3;

  // request codes
  localparam logic [1:0] REQ_PSEUDO  = 2'd0;
  localparam logic [1:0] REQ_DISP    = 2'd1;
  localparam logic [1:0] REQ_CURVE   = 2'd2;
  localparam logic [1:0] REQ_COMPUTE = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] rate_index;
    logic [4:0] factor_index;
    fx_t        pseudo_value;
    fx_t        displacement;
    fx_t        swap_rate;
    fx_t        accrual_tau;
    fx_t        annuity;
    fx_t        numeraire_ratio;
  } in_item_t;

  typedef struct packed {
    logic [4:0] drift_index;
    fx_t        drift;
    logic       last;
  } out_item_t;

  typedef enum logic {FXU_MUL, FXU_DIV} fxu_op_t;

  typedef struct packed {
    logic    start;
    fxu_op_t op;
  } fxu_req_t;

  typedef struct packed {
    logic done;
  } fxu_rsp_t;

  typedef enum logic [1:0] {FX_IDLE, FX_MUL, FX_DIV, FX_FIN} fxu_state_t;

  typedef enum logic [3:0] {
    S_IDLE, S_KINIT, S_RLOAD, S_RLAT, S_REC,
    S_DINIT, S_DLOAD, S_DLAT, S_DOP, S_EMIT, S_OWAIT
  } seq_state_t;

  // recursion micro steps
  typedef enum logic [2:0] {RS_PA, RS_SR, RS_PD, RS_PDA, RS_NUM, RS_TAU} rstep_t;

  // drift micro steps
  typedef enum logic {DS_DIV, DS_MUL} dstep_t;

  function automatic fx_t sat_add(fx_t a, fx_t b);
    logic signed [FX_W:0] s;
    s = {a[FX_W-1], a} + {b[FX_W-1], b};
    if (s[FX_W] != s[FX_W-1]) begin
      return s[FX_W] ? FX_MIN : FX_MAX;
    end
    return s[FX_W-1:0];
  endfunction

  function automatic fx_t sat_neg(fx_t a);
    return (a == FX_MIN) ? FX_MAX : -a;
  endfunction

endpackage

/* src/swap_market_model_drift.sv */
// ----------------------------------------------------------------------------
// swap_market_model_drift
// Log drifts of the coterminal swap market model from loaded pseudo-root,
// displacement and curve data, in saturating Q15.32 fixed point.
// ----------------------------------------------------------------------------
//   port group  dir  handshake             word
//   in_*        in   in_valid/in_ready     in_item_t (load or compute)
//   out_*       out  out_valid/out_ready   out_item_t (one drift)
//   cfg_*       in   cfg_valid/cfg_ready   register index and data
//
// A load word is written to its store on accept. A compute word runs a
// backward recursion per rate and factor (a multiply per step, skipped
// steps pass straight on), then a drift pass per rate and factor (a
// divide, then a multiply), bound by the one shared multiply/divide
// unit. in_ready is low from accept of a compute word with a live rate
// until the last drift word is taken; a stalled out_ready holds the sequencer.
// Reset is synchronous: registers go to 32, 32, 0, 32; stores need no clear.
// ----------------------------------------------------------------------------
module swap_market_model_drift #(
  parameter int MAX_RATES   = 32,
  parameter int MAX_FACTORS = 32,
  parameter int FRAC_BITS   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  swmd_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output swmd_pkg::out_item_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [swmd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [swmd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int RAW  = (MAX_RATES > 1) ? $clog2(MAX_RATES) : 1;
  localparam int FAW  = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
  localparam int MD   = MAX_RATES * MAX_FACTORS;
  localparam int MAW  = (MD > 1) ? $clog2(MD) : 1;
  localparam int KW   = $clog2(MAX_FACTORS + 1);
  localparam int JW   = $clog2(swmd_pkg::OUT_LIMIT + 1);
  localparam int NLIM = (MAX_RATES < swmd_pkg::OUT_LIMIT) ? MAX_RATES
                                                          : swmd_pkg::OUT_LIMIT;

  // configuration
  logic [5:0] num_rates_r, num_factors_r, numer_r;
  logic [4:0] alive_r;

  // sequencer
  swmd_pkg::seq_state_t state_r, state_nxt;
  swmd_pkg::rstep_t     rstep_r;
  swmd_pkg::dstep_t     dstep_r;
  logic                 wait_r, out_valid_r;
  swmd_pkg::out_item_t  out_data_r;

  logic [JW-1:0] n_r, al_r, num_r, j_r;
  logic [KW-1:0] nf_r, k_r;
  swmd_pkg::fx_t ratio_r, p_r, a_r, d_r, sr_r, tau_r, acd_r, bnr_rd_r;
  swmd_pkg::fx_t t_r, t1_r, bc_r, ac_cur_r, sh_r, dsum_r;

  // compute word decode
  logic [JW-1:0] n_c, al_c, num_c;
  logic [KW-1:0] nf_c;
  logic          live_c, in_acc, is_compute, rate_ok, fac_ok;

  // shared unit
  swmd_pkg::fxu_req_t fx_req;
  swmd_pkg::fxu_rsp_t fx_rsp;
  swmd_pkg::fx_t      fx_a, fx_b, fx_y;

  // stores
  swmd_pkg::fx_t  ps_rdata, disp_rdata, sr_rdata, tau_rdata, ann_rdata;
  swmd_pkg::fx_t  ac_rdata, bnr_rdata, ac_wdata, bnr_wdata;
  logic           ps_we, disp_we, curve_we, ac_we, bnr_we;
  logic [MAW-1:0] ps_waddr, ps_raddr, ac_waddr, ac_raddr;
  logic [RAW-1:0] rate_waddr, rate_raddr, tau_raddr;
  logic [FAW-1:0] bnr_addr;

  logic rec_need, rec_fin, dop_fin, j_more, k_last, j_last;

  assign n_c    = (int'(num_rates_r) > NLIM) ? JW'(NLIM) : JW'(num_rates_r);
  assign al_c   = JW'(alive_r);
  assign num_c  = (JW'(numer_r) < al_c || JW'(numer_r) > n_c) ? n_c : JW'(numer_r);
  assign nf_c   = (int'(num_factors_r) > MAX_FACTORS) ? KW'(MAX_FACTORS)
                                                      : KW'(num_factors_r);
  assign live_c = al_c < n_c;

  assign in_acc     = in_valid & in_ready;
  assign is_compute = in_data.req_type == swmd_pkg::REQ_COMPUTE;
  assign rate_ok    = int'(in_data.rate_index) < MAX_RATES;
  assign fac_ok     = int'(in_data.factor_index) < MAX_FACTORS;

  assign j_more = j_r > al_r;
  assign k_last = k_r == KW'(nf_r - KW'(1));
  assign j_last = j_r == JW'(n_r - JW'(1));

  always_comb begin
    unique case (rstep_r)
      swmd_pkg::RS_NUM: rec_need = j_r == num_r;
      swmd_pkg::RS_TAU: rec_need = j_more;
      default:          rec_need = 1'b1;
    endcase
  end

  assign rec_fin = wait_r ? fx_rsp.done : ~rec_need;
  assign dop_fin = wait_r & fx_rsp.done;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swmd_pkg::S_IDLE: begin
        if (in_acc && is_compute && live_c) begin
          state_nxt = (nf_c == '0) ? swmd_pkg::S_DINIT : swmd_pkg::S_KINIT;
        end
      end
      swmd_pkg::S_KINIT: state_nxt = swmd_pkg::S_RLOAD;
      swmd_pkg::S_RLOAD: state_nxt = swmd_pkg::S_RLAT;
      swmd_pkg::S_RLAT:  state_nxt = swmd_pkg::S_REC;
      swmd_pkg::S_REC: begin
        if (rec_fin && rstep_r == swmd_pkg::RS_TAU) begin
          if (j_more) begin
            state_nxt = swmd_pkg::S_RLOAD;
          end else begin
            state_nxt = k_last ? swmd_pkg::S_DINIT : swmd_pkg::S_KINIT;
          end
        end
      end
      swmd_pkg::S_DINIT: state_nxt = (nf_r == '0) ? swmd_pkg::S_EMIT : swmd_pkg::S_DLOAD;
      swmd_pkg::S_DLOAD: state_nxt = swmd_pkg::S_DLAT;
      swmd_pkg::S_DLAT:  state_nxt = swmd_pkg::S_DOP;
      swmd_pkg::S_DOP: begin
        if (dop_fin && dstep_r == swmd_pkg::DS_MUL) begin
          state_nxt = k_last ? swmd_pkg::S_EMIT : swmd_pkg::S_DLOAD;
        end
      end
      swmd_pkg::S_EMIT:  state_nxt = swmd_pkg::S_OWAIT;
      swmd_pkg::S_OWAIT: begin
        if (out_ready) begin
          state_nxt = j_last ? swmd_pkg::S_IDLE : swmd_pkg::S_DINIT;
        end
      end
      default: state_nxt = swmd_pkg::S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------ outputs
  always_comb begin
    in_ready     = state_r == swmd_pkg::S_IDLE;
    fx_req.start = 1'b0;
    fx_req.op    = swmd_pkg::FXU_MUL;
    fx_a         = p_r;
    fx_b         = a_r;
    ac_we        = 1'b0;
    ac_waddr     = MAW'(int'(k_r) * MAX_RATES + int'(n_r) - 1);
    ac_wdata     = '0;
    bnr_we       = 1'b0;
    bnr_wdata    = '0;
    unique case (state_r)
      swmd_pkg::S_KINIT: begin
        // last annuity covariance and default numeraire term start at zero
        ac_we  = 1'b1;
        bnr_we = 1'b1;
      end
      swmd_pkg::S_REC: begin
        fx_req.start = ~wait_r & rec_need;
        unique case (rstep_r)
          swmd_pkg::RS_PA:  begin fx_a = p_r;  fx_b = a_r; end
          swmd_pkg::RS_SR:  begin
            fx_a = sr_r;
            fx_b = swmd_pkg::sat_add(t_r, ac_cur_r);
          end
          swmd_pkg::RS_PD:  begin fx_a = p_r;  fx_b = d_r; end
          swmd_pkg::RS_PDA: begin fx_a = t_r;  fx_b = a_r; end
          swmd_pkg::RS_NUM: begin fx_a = bc_r; fx_b = ratio_r; end
          swmd_pkg::RS_TAU: begin fx_a = bc_r; fx_b = tau_r; end
          default: ;
        endcase
        if (wait_r && fx_rsp.done && rstep_r == swmd_pkg::RS_NUM) begin
          bnr_we    = 1'b1;
          bnr_wdata = fx_y;
        end
        if (wait_r && fx_rsp.done && rstep_r == swmd_pkg::RS_TAU) begin
          ac_we    = 1'b1;
          ac_waddr = MAW'(int'(k_r) * MAX_RATES + int'(j_r) - 1);
          ac_wdata = swmd_pkg::sat_add(fx_y, ac_cur_r);
        end
      end
      swmd_pkg::S_DOP: begin
        fx_req.start = ~wait_r;
        if (dstep_r == swmd_pkg::DS_DIV) begin
          fx_req.op = swmd_pkg::FXU_DIV;
          fx_a      = acd_r;
          fx_b      = a_r;
        end else begin
          fx_a = sh_r;
          fx_b = p_r;
        end
      end
      default: ;
    endcase
  end

  assign ps_we      = in_acc && in_data.req_type == swmd_pkg::REQ_PSEUDO && rate_ok && fac_ok;
  assign disp_we    = in_acc && in_data.req_type == swmd_pkg::REQ_DISP && rate_ok;
  assign curve_we   = in_acc && in_data.req_type == swmd_pkg::REQ_CURVE && rate_ok;
  assign ps_waddr   = MAW'(int'(in_data.rate_index) * MAX_FACTORS
                           + int'(in_data.factor_index));
  assign rate_waddr = RAW'(in_data.rate_index);
  assign ps_raddr   = MAW'(int'(j_r) * MAX_FACTORS + int'(k_r));
  assign ac_raddr   = MAW'(int'(k_r) * MAX_RATES + int'(j_r));
  assign rate_raddr = RAW'(j_r);
  assign tau_raddr  = RAW'(j_r - JW'(1));
  assign bnr_addr   = FAW'(k_r);

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ------------------------------------------------------------------ control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= swmd_pkg::S_IDLE;
      rstep_r       <= swmd_pkg::RS_PA;
      dstep_r       <= swmd_pkg::DS_DIV;
      wait_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      num_rates_r   <= 6'd32;
      num_factors_r <= 6'd32;
      alive_r       <= 5'd0;
      numer_r       <= 6'd32;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          swmd_pkg::REG_NUM_RATES:   num_rates_r   <= cfg_data;
          swmd_pkg::REG_NUM_FACTORS: num_factors_r <= cfg_data;
          swmd_pkg::REG_ALIVE_START: alive_r       <= cfg_data[4:0];
          swmd_pkg::REG_NUMERAIRE:   numer_r       <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        swmd_pkg::S_KINIT: rstep_r <= swmd_pkg::RS_PA;
        swmd_pkg::S_REC: begin
          if (fx_req.start) begin
            wait_r <= 1'b1;
          end else if (rec_fin) begin
            wait_r <= 1'b0;
            unique case (rstep_r)
              swmd_pkg::RS_PA:  rstep_r <= swmd_pkg::RS_SR;
              swmd_pkg::RS_SR:  rstep_r <= swmd_pkg::RS_PD;
              swmd_pkg::RS_PD:  rstep_r <= swmd_pkg::RS_PDA;
              swmd_pkg::RS_PDA: rstep_r <= swmd_pkg::RS_NUM;
              swmd_pkg::RS_NUM: rstep_r <= swmd_pkg::RS_TAU;
              default:          rstep_r <= swmd_pkg::RS_PA;
            endcase
          end
        end
        swmd_pkg::S_DINIT: dstep_r <= swmd_pkg::DS_DIV;
        swmd_pkg::S_DOP: begin
          if (fx_req.start) begin
            wait_r <= 1'b1;
          end else if (dop_fin) begin
            wait_r  <= 1'b0;
            dstep_r <= (dstep_r == swmd_pkg::DS_DIV) ? swmd_pkg::DS_MUL
                                                     : swmd_pkg::DS_DIV;
          end
        end
        swmd_pkg::S_EMIT:  out_valid_r <= 1'b1;
        swmd_pkg::S_OWAIT: if (out_ready) out_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // ----------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      swmd_pkg::S_IDLE: begin
        if (in_acc && is_compute) begin
          n_r     <= n_c;
          nf_r    <= nf_c;
          al_r    <= al_c;
          num_r   <= num_c;
          ratio_r <= in_data.numeraire_ratio;
          k_r     <= '0;
          j_r     <= al_c;
        end
      end
      swmd_pkg::S_KINIT: begin
        j_r      <= JW'(n_r - JW'(1));
        ac_cur_r <= '0;
      end
      swmd_pkg::S_RLAT: begin
        p_r   <= ps_rdata;
        a_r   <= ann_rdata;
        d_r   <= disp_rdata;
        sr_r  <= sr_rdata;
        tau_r <= tau_rdata;
      end
      swmd_pkg::S_REC: begin
        if (wait_r && fx_rsp.done) begin
          unique case (rstep_r)
            swmd_pkg::RS_PA:  t_r      <= fx_y;
            swmd_pkg::RS_SR:  t1_r     <= fx_y;
            swmd_pkg::RS_PD:  t_r      <= fx_y;
            swmd_pkg::RS_PDA: bc_r     <= swmd_pkg::sat_add(t1_r, fx_y);
            swmd_pkg::RS_TAU: ac_cur_r <= swmd_pkg::sat_add(fx_y, ac_cur_r);
            default: ;
          endcase
        end
        if (rec_fin && rstep_r == swmd_pkg::RS_TAU) begin
          if (j_more) begin
            j_r <= j_r - JW'(1);
          end else if (k_last) begin
            j_r <= al_r;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
      end
      swmd_pkg::S_DINIT: begin
        dsum_r <= '0;
        k_r    <= '0;
      end
      swmd_pkg::S_DLAT: begin
        acd_r    <= ac_rdata;
        a_r      <= ann_rdata;
        p_r      <= ps_rdata;
        bnr_rd_r <= bnr_rdata;
      end
      swmd_pkg::S_DOP: begin
        if (dop_fin) begin
          if (dstep_r == swmd_pkg::DS_DIV) begin
            sh_r <= swmd_pkg::sat_add(swmd_pkg::sat_neg(fx_y), bnr_rd_r);
          end else begin
            dsum_r <= swmd_pkg::sat_add(dsum_r, fx_y);
            if (!k_last) k_r <= k_r + KW'(1);
          end
        end
      end
      swmd_pkg::S_EMIT: begin
        out_data_r.drift_index <= j_r[4:0];
        out_data_r.drift       <= dsum_r;
        out_data_r.last        <= j_last;
      end
      swmd_pkg::S_OWAIT: if (out_ready && !j_last) j_r <= j_r + JW'(1);
      default: ;
    endcase
  end

  // ------------------------------------------------------------------- units
  swmd_fxu #(.FRAC_BITS(FRAC_BITS)) u_fxu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fx_req),
    .a     (fx_a),
    .b     (fx_b),
    .rsp   (fx_rsp),
    .y     (fx_y)
  );

  swmd_ram #(.WIDTH(swmd_pkg::FX_W), .DEPTH(MD)) u_pseudo (
    .clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(in_data.pseudo_value),
    .raddr(ps_raddr), .rdata(ps_rdata)
  );

  swmd_ram #(.WIDTH(swmd_pkg::FX_W), .DEPTH(MAX_RATES)) u_disp (
    .clk(clk), .we(disp_we), .waddr(rate_waddr), .wdata(in_data.displacement),
    .raddr(rate_raddr), .rdata(disp_rdata)
  );

  swmd_ram #(.WIDTH(swmd_pkg::FX_W), .DEPTH(MAX_RATES)) u_swap_rate (
    .clk(clk), .we(curve_we), .waddr(rate_waddr), .wdata(in_data.swap_rate),
    .raddr(rate_raddr), .rdata(sr_rdata)
  );

  swmd_ram #(.WIDTH(swmd_pkg::FX_W), .DEPTH(MAX_RATES)) u_tau (
    .clk(clk), .we(curve_we), .waddr(rate_waddr), .wdata(in_data.accrual_tau),
    .raddr(tau_raddr), .rdata(tau_rdata)
  );

  swmd_ram #(.WIDTH(swmd_pkg::FX_W), .DEPTH(MAX_RATES)) u_annuity (
    .clk(clk), .we(curve_we), .waddr(rate_waddr), .wdata(in_data.annuity),
    .raddr(rate_raddr), .rdata(ann_rdata)
  );

  // annuity covariance, row per factor
  swmd_ram #(.WIDTH(swmd_pkg::FX_W), .DEPTH(MD)) u_ann_cov (
    .clk(clk), .we(ac_we), .waddr(ac_waddr), .wdata(ac_wdata),
    .raddr(ac_raddr), .rdata(ac_rdata)
  );

  // numeraire bond covariance times ratio, one per factor
  swmd_ram #(.WIDTH(swmd_pkg::FX_W), .DEPTH(MAX_FACTORS)) u_bond_num (
    .clk(clk), .we(bnr_we), .waddr(bnr_addr), .wdata(bnr_wdata),
    .raddr(bnr_addr), .rdata(bnr_rdata)
  );

endmodule

/* src/swmd_ram.sv */
// ----------------------------------------------------------------------------
// swmd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module swmd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/swmd_fxu.sv */
// ----------------------------------------------------------------------------
// swmd_fxu
// Shared fixed point unit: rounded saturating multiply over four 24x24
// partial products, and rounded saturating divide one quotient bit a cycle.
// ----------------------------------------------------------------------------
module swmd_fxu #(
  parameter int FRAC_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  swmd_pkg::fxu_req_t req,
  input  swmd_pkg::fx_t      a,
  input  swmd_pkg::fx_t      b,
  output swmd_pkg::fxu_rsp_t rsp,
  output swmd_pkg::fx_t      y
);

  localparam int W  = swmd_pkg::FX_W;
  localparam int HW = W / 2;
  localparam int PW = 2 * W;
  localparam int DW = W + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  swmd_pkg::fxu_state_t state_r, state_nxt;
  swmd_pkg::fxu_op_t    op_r;
  logic                 neg_r, zero_r, inf_r, over_r, done_r;
  logic [W-1:0]         ua_r, ub_r, q_r, rem_r;
  logic [PW-1:0]        acc_r;
  logic [1:0]           step_r;
  logic [DW-1:0]        dvd_r;
  logic [CW-1:0]        cnt_r;
  swmd_pkg::fx_t        y_r;

  logic [W-1:0]  ua_c, ub_c, lim, mag;
  logic [HW-1:0] ah, bh;
  logic [W-1:0]  pp;
  logic [PW-1:0] pp_sh, rnd, qm;
  logic [W:0]    r2, q2;
  logic          ge, rbit;

  assign ua_c = a[W-1] ? W'(-a) : W'(a);
  assign ub_c = b[W-1] ? W'(-b) : W'(b);

  always_comb begin
    ah = step_r[1] ? ua_r[W-1:HW] : ua_r[HW-1:0];
    bh = step_r[0] ? ub_r[W-1:HW] : ub_r[HW-1:0];
    pp = W'(ah) * W'(bh);
    if (step_r[1] & step_r[0]) begin
      pp_sh = PW'(pp) << W;
    end else if (step_r[1] ^ step_r[0]) begin
      pp_sh = PW'(pp) << HW;
    end else begin
      pp_sh = PW'(pp);
    end
  end

  // one restoring division step
  always_comb begin
    r2 = {rem_r, dvd_r[DW-1]};
    ge = r2 >= {1'b0, ub_r};
  end

  always_comb begin
    lim  = neg_r ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    rnd  = acc_r + (PW'(1) << (FRAC_BITS - 1));
    qm   = rnd >> FRAC_BITS;
    rbit = {rem_r, 1'b0} >= {1'b0, ub_r};
    q2   = {1'b0, q_r} + (W+1)'(rbit);
    if (op_r == swmd_pkg::FXU_MUL) begin
      mag = (qm > PW'(lim)) ? lim : qm[W-1:0];
    end else if (zero_r) begin
      mag = '0;
    end else if (inf_r || over_r || q2 > {1'b0, lim}) begin
      mag = lim;
    end else begin
      mag = q2[W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swmd_pkg::FX_IDLE: begin
        if (req.start) begin
          if (req.op == swmd_pkg::FXU_MUL) begin
            state_nxt = swmd_pkg::FX_MUL;
          end else if (ua_c == '0 || ub_c == '0) begin
            state_nxt = swmd_pkg::FX_FIN;
          end else begin
            state_nxt = swmd_pkg::FX_DIV;
          end
        end
      end
      swmd_pkg::FX_MUL: if (step_r == 2'd3) state_nxt = swmd_pkg::FX_FIN;
      swmd_pkg::FX_DIV: if (cnt_r == CW'(DW - 1)) state_nxt = swmd_pkg::FX_FIN;
      swmd_pkg::FX_FIN: state_nxt = swmd_pkg::FX_IDLE;
      default:          state_nxt = swmd_pkg::FX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swmd_pkg::FX_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == swmd_pkg::FX_FIN);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      swmd_pkg::FX_IDLE: begin
        if (req.start) begin
          op_r   <= req.op;
          ua_r   <= ua_c;
          ub_r   <= ub_c;
          zero_r <= (req.op == swmd_pkg::FXU_DIV) && (ua_c == '0);
          inf_r  <= (req.op == swmd_pkg::FXU_DIV) && (ua_c != '0) && (ub_c == '0);
          // divide by zero takes the sign of the numerator alone
          neg_r  <= ((req.op == swmd_pkg::FXU_DIV) && (ub_c == '0)) ? a[W-1]
                                                                   : (a[W-1] ^ b[W-1]);
          acc_r  <= '0;
          step_r <= '0;
          dvd_r  <= {ua_c, {FRAC_BITS{1'b0}}};
          rem_r  <= '0;
          q_r    <= '0;
          over_r <= 1'b0;
          cnt_r  <= '0;
        end
      end
      swmd_pkg::FX_MUL: begin
        acc_r  <= acc_r + pp_sh;
        step_r <= step_r + 2'd1;
      end
      swmd_pkg::FX_DIV: begin
        dvd_r  <= dvd_r << 1;
        rem_r  <= ge ? W'(r2 - {1'b0, ub_r}) : r2[W-1:0];
        over_r <= over_r | q_r[W-1];
        q_r    <= {q_r[W-2:0], ge};
        cnt_r  <= cnt_r + CW'(1);
      end
      swmd_pkg::FX_FIN: begin
        y_r <= swmd_pkg::fx_t'(neg_r ? (~mag + W'(1)) : mag);
      end
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign y        = y_r;

endmodule

/* dv/tb_swap_market_model_drift.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_swap_market_model_drift
// Self-checking bench for the swap market model drift block. An initial
// block stages load and compute words per configuration phase. A clocked
// driver and a clocked monitor handle the handshakes with random idle cycles.
// A fixed point predictor computes the expected drift words for each compute
// word as it is accepted.
// ----------------------------------------------------------------------------
module tb_swap_market_model_drift;

  localparam int NR = 32;
  localparam int NF = 32;
  localparam int FRAC = 32;
  localparam int FXW = swmd_pkg::FX_W;
  localparam logic [swmd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam swmd_pkg::fx_t FX_ONE = swmd_pkg::fx_t'(64'sd1 <<< FRAC);

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  swmd_pkg::in_item_t in_data;
  swmd_pkg::out_item_t out_data;
  logic [swmd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [swmd_pkg::CFG_DATA_W-1:0] cfg_data;

  swap_market_model_drift dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [5:0] reg_rates, reg_factors, reg_numer;
  logic [4:0] reg_alive;
  swmd_pkg::fx_t pseudo_m [NR][NF];
  swmd_pkg::fx_t disp_m [NR];
  swmd_pkg::fx_t swap_m [NR];
  swmd_pkg::fx_t tau_m [NR];
  swmd_pkg::fx_t ann_m [NR];
  swmd_pkg::fx_t ann_cov [NF][NR];
  swmd_pkg::fx_t bond_cov [NF][NR+1];

  swmd_pkg::out_item_t drift_q [$];
  swmd_pkg::in_item_t pending_words [$];
  int words_staged = 0;
  int words_taken = 0;
  int errors = 0;

  // what the staged sequence has written so far
  bit pseudo_loaded [NR][NF];
  bit disp_loaded [NR];
  bit curve_loaded [NR];

  function automatic logic [127:0] mag(swmd_pkg::fx_t v);
    return v[FXW-1] ? 128'(-longint'(v)) : 128'(longint'(v));
  endfunction

  function automatic swmd_pkg::fx_t clamp_mag(logic neg, logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? (128'(1) << (FXW-1)) : (128'(1) << (FXW-1)) - 1;
    if (m > lim) m = lim;
    return neg ? swmd_pkg::fx_t'(-m[FXW-1:0]) : swmd_pkg::fx_t'(m[FXW-1:0]);
  endfunction

  function automatic swmd_pkg::fx_t add_sat(swmd_pkg::fx_t a, swmd_pkg::fx_t b);
    logic signed [FXW:0] s;
    s = {a[FXW-1], a} + {b[FXW-1], b};
    if (s[FXW] != s[FXW-1]) return s[FXW] ? swmd_pkg::FX_MIN : swmd_pkg::FX_MAX;
    return s[FXW-1:0];
  endfunction

  function automatic swmd_pkg::fx_t neg_sat(swmd_pkg::fx_t a);
    return (a == swmd_pkg::FX_MIN) ? swmd_pkg::FX_MAX : -a;
  endfunction

  function automatic swmd_pkg::fx_t mul_round(swmd_pkg::fx_t a, swmd_pkg::fx_t b);
    logic [127:0] p;
    p = (mag(a) * mag(b) + (128'(1) << (FRAC-1))) >> FRAC;
    return clamp_mag(a[FXW-1] ^ b[FXW-1], p);
  endfunction

  function automatic swmd_pkg::fx_t div_round(swmd_pkg::fx_t a, swmd_pkg::fx_t b);
    logic [127:0] ma, mb, q, r;
    ma = mag(a);
    mb = mag(b);
    if (ma == 0) return '0;
    // divide by zero: saturate with the numerator sign
    if (mb == 0) return clamp_mag(a[FXW-1], 128'(1) << 100);
    q = (ma << FRAC) / mb;
    r = (ma << FRAC) % mb;
    if (2 * r >= mb) q = q + 1;
    return clamp_mag(a[FXW-1] ^ b[FXW-1], q);
  endfunction

  function automatic int live_rates();
    return (reg_rates > NR) ? NR : int'(reg_rates);
  endfunction

  function automatic int live_factors();
    return (reg_factors > NF) ? NF : int'(reg_factors);
  endfunction

  task automatic predict_drifts(swmd_pkg::fx_t ratio);
    int n, nf, al, num;
    swmd_pkg::fx_t p, a, t1, t2, d, sh;
    swmd_pkg::out_item_t o;
    n = live_rates();
    nf = live_factors();
    al = reg_alive;
    if (al >= n) return;
    num = reg_numer;
    if (num < al || num > n) num = n;
    for (int k = 0; k < nf; k++) begin
      ann_cov[k][n-1] = '0;
      bond_cov[k][n] = '0;
      for (int j = n - 1; j >= al; j--) begin
        p = pseudo_m[j][k];
        a = ann_m[j];
        t1 = mul_round(swap_m[j], add_sat(mul_round(p, a), ann_cov[k][j]));
        t2 = mul_round(mul_round(p, disp_m[j]), a);
        bond_cov[k][j] = add_sat(t1, t2);
        if (j > al)
          ann_cov[k][j-1] = add_sat(mul_round(bond_cov[k][j], tau_m[j-1]), ann_cov[k][j]);
      end
    end
    for (int j = al; j < n; j++) begin
      d = '0;
      for (int k = 0; k < nf; k++) begin
        sh = add_sat(neg_sat(div_round(ann_cov[k][j], ann_m[j])),
                     mul_round(bond_cov[k][num], ratio));
        d = add_sat(d, mul_round(sh, pseudo_m[j][k]));
      end
      o.drift_index = j[4:0];
      o.drift = d;
      o.last = (j == n - 1);
      drift_q.push_back(o);
    end
  endtask

  task automatic absorb_word(swmd_pkg::in_item_t w);
    case (w.req_type)
      swmd_pkg::REQ_PSEUDO: pseudo_m[w.rate_index][w.factor_index] = w.pseudo_value;
      swmd_pkg::REQ_DISP: disp_m[w.rate_index] = w.displacement;
      swmd_pkg::REQ_CURVE: begin
        swap_m[w.rate_index] = w.swap_rate;
        tau_m[w.rate_index] = w.accrual_tau;
        ann_m[w.rate_index] = w.annuity;
      end
      default: predict_drifts(w.numeraire_ratio);
    endcase
  endtask

  // driver
  int in_gap;
  bit in_burst;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      in_gap = 0;
      in_burst = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_word(in_data);
        words_taken++;
        if ($urandom_range(0, 19) == 0) in_burst = ~in_burst;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_words.pop_front();
          in_gap = in_burst ? 0 : $urandom_range(0, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_stall;
  bit out_burst;
  always @(posedge clk) begin
    swmd_pkg::out_item_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
      out_burst = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (drift_q.size() == 0) begin
          $display("%0t: unexpected drift word %p", $time, out_data);
          errors++;
        end else begin
          e = drift_q.pop_front();
          if (out_data.drift_index !== e.drift_index) begin
            $display("%0t: drift_index expected %0d actual %0d", $time,
                     e.drift_index, out_data.drift_index);
            errors++;
          end
          if (out_data.drift !== e.drift) begin
            $display("%0t: drift[%0d] expected %h actual %h", $time,
                     e.drift_index, e.drift, out_data.drift);
            errors++;
          end
          if (out_data.last !== e.last) begin
            $display("%0t: last[%0d] expected %b actual %b", $time,
                     e.drift_index, e.last, out_data.last);
            errors++;
          end
        end
        if ($urandom_range(0, 19) == 0) out_burst = ~out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 11);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic swmd_pkg::fx_t rand_fx();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return swmd_pkg::fx_t'({$urandom, $urandom});
    if (sel == 1) begin
      case ($urandom_range(0, 4))
        0: return '0;
        1: return swmd_pkg::FX_MAX;
        2: return swmd_pkg::FX_MIN;
        3: return FX_ONE;
        default: return -FX_ONE;
      endcase
    end
    return swmd_pkg::fx_t'(longint'($signed($urandom)) <<< $urandom_range(0, 2));
  endfunction

  function automatic swmd_pkg::in_item_t noise_word();
    swmd_pkg::in_item_t w;
    w.req_type = 2'($urandom_range(swmd_pkg::REQ_PSEUDO, swmd_pkg::REQ_CURVE));
    w.rate_index = 5'($urandom);
    w.factor_index = 5'($urandom);
    w.pseudo_value = rand_fx();
    w.displacement = rand_fx();
    w.swap_rate = rand_fx();
    w.accrual_tau = rand_fx();
    w.annuity = ($urandom_range(0, 7) == 0) ? '0 : rand_fx();
    w.numeraire_ratio = rand_fx();
    return w;
  endfunction

  task automatic stage(swmd_pkg::in_item_t w);
    pending_words.push_back(w);
    words_staged++;
    case (w.req_type)
      swmd_pkg::REQ_PSEUDO: pseudo_loaded[w.rate_index][w.factor_index] = 1'b1;
      swmd_pkg::REQ_DISP: disp_loaded[w.rate_index] = 1'b1;
      swmd_pkg::REQ_CURVE: curve_loaded[w.rate_index] = 1'b1;
      default: ;
    endcase
  endtask

  task automatic write_reg(logic [swmd_pkg::CFG_IDX_W-1:0] idx,
                           logic [swmd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      swmd_pkg::REG_NUM_RATES: reg_rates = val;
      swmd_pkg::REG_NUM_FACTORS: reg_factors = val;
      swmd_pkg::REG_ALIVE_START: reg_alive = val[4:0];
      swmd_pkg::REG_NUMERAIRE: reg_numer = val;
      default: ;
    endcase
  endtask

  // hold until every staged word is taken, every drift is back and the
  // block is ready again; computes without results still need the pause
  task automatic settle();
    while (words_taken != words_staged || drift_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic run_phase(int n, int nf, int al, int num, int computes);
    swmd_pkg::in_item_t w;
    int ne, fe, ae;
    settle();
    write_reg(swmd_pkg::REG_NUM_RATES, 6'(n));
    write_reg(swmd_pkg::REG_NUM_FACTORS, 6'(nf));
    write_reg(swmd_pkg::REG_ALIVE_START, 6'(al));
    write_reg(swmd_pkg::REG_NUMERAIRE, 6'(num));
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 6'($urandom));
    ne = live_rates();
    fe = live_factors();
    // the block keeps only the low bits of the alive index
    ae = int'(reg_alive);
    for (int c = 0; c < computes; c++) begin
      for (int j = ae; j < ne; j++) begin
        for (int k = 0; k < fe; k++) begin
          if (!pseudo_loaded[j][k] || $urandom_range(0, 1)) begin
            w = noise_word();
            w.req_type = swmd_pkg::REQ_PSEUDO;
            w.rate_index = 5'(j);
            w.factor_index = 5'(k);
            stage(w);
          end
        end
        if (!disp_loaded[j] || $urandom_range(0, 1)) begin
          w = noise_word();
          w.req_type = swmd_pkg::REQ_DISP;
          w.rate_index = 5'(j);
          stage(w);
        end
        if (!curve_loaded[j] || $urandom_range(0, 1)) begin
          w = noise_word();
          w.req_type = swmd_pkg::REQ_CURVE;
          w.rate_index = 5'(j);
          stage(w);
        end
      end
      repeat ($urandom_range(0, 4)) stage(noise_word());
      w = noise_word();
      w.req_type = swmd_pkg::REQ_COMPUTE;
      stage(w);
    end
  endtask

  initial begin
    int n, al;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reg_rates = 6'd32;
    reg_factors = 6'd32;
    reg_alive = '0;
    reg_numer = 6'd32;
    for (int k = 0; k < NF; k++) begin
      for (int j = 0; j < NR; j++) ann_cov[k][j] = '0;
      for (int j = 0; j <= NR; j++) bond_cov[k][j] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // corners: small case, single rate, full rate count, clamped counts,
    // numeraire below alive and above count, no live rate, zero factors
    run_phase(4, 2, 0, 4, 2);
    run_phase(1, 1, 0, 0, 1);
    run_phase(32, 1, 0, 32, 1);
    run_phase(63, 63, 31, 30, 1);
    run_phase(5, 3, 2, 0, 1);
    run_phase(6, 2, 1, 40, 1);
    run_phase(0, 1, 0, 0, 1);
    run_phase(3, 0, 0, 1, 1);
    run_phase(3, 5, 3, 3, 1);
    run_phase(2, 16, 0, 1, 1);

    while (words_staged < 260) begin
      n = $urandom_range(1, 8);
      al = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
      run_phase(n, $urandom_range(0, 4), al,
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n + 1),
                $urandom_range(1, 2));
    end
    settle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #36_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
